/* hw/rtl/sil_pkg.sv */
// Shared types and constants for the shadow interval line core.
`default_nettype none
package sil_pkg;

   localparam int MAX_SHADOWS_DEF = 32;
   localparam int MAX_ROW_DEF     = 255;

   localparam int ROW_W  = 8;
   localparam int COL_W  = 8;
   localparam int FRAC_W = 9;   // width of a denominator or of an end numerator
   localparam int PROD_W = 18;  // width of one cross product

   typedef struct packed {
      logic             new_line;
      logic [ROW_W-1:0] tile_row;
      logic [COL_W-1:0] tile_col;
      logic             opaque;
   } req_type;

   typedef struct packed {
      logic visible;
      logic full_shadow;
      logic table_overflow;
   } rsp_type;

   // one shadow: start sn/sd, end en/ed
   typedef struct packed {
      logic [COL_W-1:0]  sn;
      logic [FRAC_W-1:0] sd;
      logic [FRAC_W-1:0] en;
      logic [FRAC_W-1:0] ed;
   } entry_type;

   typedef enum logic [1:0] {
      MODE_BOTH,
      MODE_NEXT,
      MODE_PREV,
      MODE_INSERT
   } merge_mode_type;

   typedef struct packed {
      logic           compare;
      logic           apply;
      merge_mode_type mode;
   } cell_ctrl_type;

   typedef struct packed {
      logic covered;
      logic prev_hit;
      logic next_hit;
   } cell_hit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } sil_state_type;

endpackage
`default_nettype wire

/* hw/rtl/sil_cell.sv */
// One cell of the shadow line: holds one shadow, compares it with the tile, shifts.
`default_nettype none
module sil_cell (
   input  wire logic                  clock,
   input  wire sil_pkg::entry_type     p,
   input  wire logic                  valid,
   input  wire logic                  left_lt,
   input  wire logic                  right_lt,
   input  wire sil_pkg::entry_type     left_entry,
   input  wire sil_pkg::entry_type     right_entry,
   input  wire sil_pkg::cell_ctrl_type ctrl,
   output      sil_pkg::entry_type     entry,
   output      logic                  lt_v,
   output      sil_pkg::cell_hit_type  hit
);
   import sil_pkg::*;

   typedef struct packed {
      logic le_start;
      logic lt_start;
      logic le_end;
      logic prev_ov;
      logic next_ov;
   } cmp_flags_type;

   entry_type     entry_ff, entry_in;
   cmp_flags_type flags_ff, flags_in;

   logic [PROD_W-1:0] s_x_pd, ps_x_sd, pe_x_ed, e_x_ped, ps_x_ed, e_x_psd, s_x_ped, pe_x_sd;
   logic at_idx, above, is_prev;

   // cross products of the stored shadow against the tile projection
   assign s_x_pd  = PROD_W'(entry_ff.sn) * PROD_W'(p.sd);
   assign ps_x_sd = PROD_W'(p.sn) * PROD_W'(entry_ff.sd);
   assign pe_x_ed = PROD_W'(p.en) * PROD_W'(entry_ff.ed);
   assign e_x_ped = PROD_W'(entry_ff.en) * PROD_W'(p.ed);
   assign ps_x_ed = PROD_W'(p.sn) * PROD_W'(entry_ff.ed);
   assign e_x_psd = PROD_W'(entry_ff.en) * PROD_W'(p.sd);
   assign s_x_ped = PROD_W'(entry_ff.sn) * PROD_W'(p.ed);
   assign pe_x_sd = PROD_W'(p.en) * PROD_W'(entry_ff.sd);

   always_comb begin
      flags_in.le_start = s_x_pd <= ps_x_sd;
      flags_in.lt_start = s_x_pd < ps_x_sd;
      flags_in.le_end   = pe_x_ed <= e_x_ped;
      flags_in.prev_ov  = ps_x_ed < e_x_psd;
      flags_in.next_ov  = s_x_ped < pe_x_sd;
   end

   // position relative to the insertion point (list is sorted by start)
   assign lt_v    = valid & flags_ff.lt_start;
   assign at_idx  = ~lt_v & left_lt;
   assign above   = ~lt_v & ~left_lt;
   assign is_prev = lt_v & ~right_lt;

   assign hit.covered  = valid & flags_ff.le_start & flags_ff.le_end;
   assign hit.prev_hit = is_prev & flags_ff.prev_ov;
   assign hit.next_hit = at_idx & valid & flags_ff.next_ov;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.apply) begin
         case (ctrl.mode)
            MODE_BOTH: begin
               if (is_prev) begin
                  entry_in.en = right_entry.en;
                  entry_in.ed = right_entry.ed;
               end else if (at_idx || above) begin
                  entry_in = right_entry;
               end
            end
            MODE_NEXT: begin
               if (at_idx) begin
                  entry_in.sn = p.sn;
                  entry_in.sd = p.sd;
               end
            end
            MODE_PREV: begin
               if (is_prev) begin
                  entry_in.en = p.en;
                  entry_in.ed = p.ed;
               end
            end
            MODE_INSERT: begin
               if (at_idx) begin
                  entry_in = p;
               end else if (above) begin
                  entry_in = left_entry;
               end
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         flags_ff <= flags_in;
      end
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

/* hw/rtl/shadow_interval_line_core.sv */
// Top level of the shadow interval line: control, shadow count and the row of cells.
`default_nettype none
// Shadow interval line core. Each transfer on the request side is one tile of an
// octant scan (row, column, opaque flag, new_line). The tile is projected to the
// interval [col/(row+2), (col+1)/(row+1)], kept as exact fractions. A row of
// MAX_SHADOWS cells holds the sorted shadow list, one shadow per cell; every cell
// compares its shadow with the tile by cross multiplication in parallel, and the
// list is then merged or shifted one place left or right through the neighbor
// links. A tile is taken when start is high and busy is low; busy stays high
// through the compare state and the update state, so no new tile is taken until
// the last one is done. The compare and update stages of the cell row set how
// long busy lasts; it does not depend on how many shadows are stored. The result
// appears on rsp_data for exactly one cycle with rsp_strobe high, in the cycle
// after the update, and is taken at the edge that ends it.
// The receiver cannot stall:
// a result not taken in its strobe cycle is lost. new_line empties the list in
// the accepting cycle. An opaque visible tile that merges with no neighbor while
// all cells are in use is dropped and reported by table_overflow. Stored shadows
// have no reset value; no clearing pass is needed, only the count is cleared.
module shadow_interval_line_core #(
   parameter int MAX_SHADOWS = sil_pkg::MAX_SHADOWS_DEF,
   parameter int MAX_ROW     = sil_pkg::MAX_ROW_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output      logic             busy,
   input  wire sil_pkg::req_type req_data,
   output      logic             rsp_strobe,
   output      sil_pkg::rsp_type rsp_data
);
   import sil_pkg::*;

   localparam int CNT_W = $clog2(MAX_SHADOWS + 1);

   sil_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   entry_type         p_ff, p_in;
   logic              opaque_ff;
   logic              visible_ff, visible_in;
   logic              overflow_ff, overflow_in;
   logic              strobe_ff, strobe_in;

   cell_ctrl_type     ctrl;
   logic              accept;
   logic [ROW_W-1:0]  row_sat;

   entry_type         entry_w [MAX_SHADOWS];
   logic              lt_w    [MAX_SHADOWS];
   cell_hit_type      hit_w   [MAX_SHADOWS];
   logic [MAX_SHADOWS-1:0] covered_vec, prev_vec, next_vec, valid_vec;

   logic prev_ov, next_ov, take, drop;
   merge_mode_type mode;

   assign accept = start & ~busy;

   // project the tile; saturate the row first
   always_comb begin
      row_sat = req_data.tile_row;
      if (int'(req_data.tile_row) > MAX_ROW) begin
         row_sat = ROW_W'(MAX_ROW);
      end
      p_in.sn = req_data.tile_col;
      p_in.sd = FRAC_W'(row_sat) + FRAC_W'(2);
      p_in.en = FRAC_W'(req_data.tile_col) + FRAC_W'(1);
      p_in.ed = FRAC_W'(row_sat) + FRAC_W'(1);
   end

   // row of cells; each sees its neighbors' position flags and shadows
   for (genvar i = 0; i < MAX_SHADOWS; i++) begin : g_cell
      logic      left_lt, right_lt;
      entry_type left_entry, right_entry;

      assign valid_vec[i] = count_ff > CNT_W'(i);

      if (i == 0) begin : g_first
         assign left_lt    = 1'b1;
         assign left_entry = entry_w[i];
      end else begin : g_inner_l
         assign left_lt    = lt_w[i-1];
         assign left_entry = entry_w[i-1];
      end

      if (i == MAX_SHADOWS - 1) begin : g_last
         assign right_lt    = 1'b0;
         assign right_entry = entry_w[i];
      end else begin : g_inner_r
         assign right_lt    = lt_w[i+1];
         assign right_entry = entry_w[i+1];
      end

      sil_cell u_cell (
         .clock       (clock),
         .p           (p_ff),
         .valid       (valid_vec[i]),
         .left_lt     (left_lt),
         .right_lt    (right_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .ctrl        (ctrl),
         .entry       (entry_w[i]),
         .lt_v        (lt_w[i]),
         .hit         (hit_w[i])
      );

      assign covered_vec[i] = hit_w[i].covered;
      assign prev_vec[i]    = hit_w[i].prev_hit;
      assign next_vec[i]    = hit_w[i].next_hit;
   end

   // merge decision from the registered cell flags
   always_comb begin
      visible_in = ~|covered_vec;
      prev_ov    = |prev_vec;
      next_ov    = |next_vec;
      take       = visible_in & opaque_ff;
      drop       = ~prev_ov & ~next_ov & (count_ff == CNT_W'(MAX_SHADOWS));
      if (prev_ov && next_ov) begin
         mode = MODE_BOTH;
      end else if (next_ov) begin
         mode = MODE_NEXT;
      end else if (prev_ov) begin
         mode = MODE_PREV;
      end else begin
         mode = MODE_INSERT;
      end
   end

   // sequencer: next state, cell control, count and result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ctrl.compare = 1'b0;
      ctrl.apply   = 1'b0;
      ctrl.mode    = mode;
      strobe_in    = 1'b0;
      overflow_in  = overflow_ff;
      busy         = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ST_COMPARE;
               if (req_data.new_line) begin
                  count_in = '0;
               end
            end
         end
         ST_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            ctrl.apply  = take & ~drop;
            overflow_in = take & drop;
            strobe_in   = 1'b1;
            state_in    = ST_IDLE;
            if (take && !drop) begin
               case (mode)
                  MODE_BOTH:   count_in = count_ff - CNT_W'(1);
                  MODE_INSERT: count_in = count_ff + CNT_W'(1);
                  default:     count_in = count_ff;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload: hold the projection for the compare and update cycles
   always_ff @(posedge clock) begin
      if (accept) begin
         p_ff      <= p_in;
         opaque_ff <= req_data.opaque;
      end
      if (strobe_in) begin
         visible_ff  <= visible_in;
         overflow_ff <= overflow_in;
      end
   end

   // full shadow: a single shadow spanning 0 to 1, read from the updated list
   assign rsp_strobe              = strobe_ff;
   assign rsp_data.visible        = visible_ff;
   assign rsp_data.table_overflow = overflow_ff;
   assign rsp_data.full_shadow    = (count_ff == CNT_W'(1)) && (entry_w[0].sn == '0)
                                    && (entry_w[0].en == entry_w[0].ed);

endmodule
`default_nettype wire
